### design/nmea_sentence_receiver_unit_assert.svh
// Assertion macros for the sentence receiver execute side (nsr_back).
`ifndef NMEA_SENTENCE_RECEIVER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_RECEIVER_UNIT_ASSERT_SVH

// Expression holds at every clock edge out of reset.
`define NSR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define NSR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define NSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/nsr_pkg.sv
// Types and constants shared by the sentence receiver modules.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    localparam int MAX_LEN     = 128;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int COUNT_W     = $clog2(MAX_LEN + 1);
    localparam int PREFIX_LEN  = 6;
    localparam int PFX_IDX_W   = $clog2(PREFIX_LEN);
    localparam int TARGET_W    = 8 * PREFIX_LEN;
    localparam int IDX_W       = 7;
    localparam int LEN_W       = 8;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NOP     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_MATCH  = 3'd1,
        EV_PREFIX = 3'd2,
        EV_CSUM   = 3'd3,
        EV_ABORT  = 3'd4,
        EV_READ   = 3'd5
    } t_event;

    typedef struct packed {
        t_kind              kind;
        logic               is_dollar;
        logic               is_crlf;
        logic [7:0]         data;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

endpackage

`default_nettype wire

### design/nsr_front.sv
// Input side: accepts stream words and decodes them into commands.
`timescale 1ns / 1ps
`default_nettype none

module nsr_front (
    input  wire logic                      i_tvalid,
    output logic                           o_tready,
    input  wire logic [1:0]                i_action,
    input  wire logic [7:0]                i_byte,
    input  wire logic [nsr_pkg::IDX_W-1:0] i_idx,
    input  wire logic                      i_queue_full,
    output logic                           o_push,
    output nsr_pkg::t_cmd                  o_cmd
);

    assign o_tready = !i_queue_full;
    assign o_push   = i_tvalid && !i_queue_full;

    always_comb begin
        o_cmd.data      = i_byte;
        o_cmd.idx       = i_idx;
        o_cmd.is_dollar = (i_byte == nsr_pkg::CHAR_DOLLAR);
        o_cmd.is_crlf   = (i_byte == nsr_pkg::CHAR_CR) || (i_byte == nsr_pkg::CHAR_LF);
        unique case (i_action)
            nsr_pkg::ACT_BYTE:    o_cmd.kind = nsr_pkg::KIND_BYTE;
            nsr_pkg::ACT_RELEASE: o_cmd.kind = nsr_pkg::KIND_RELEASE;
            nsr_pkg::ACT_READ:    o_cmd.kind = nsr_pkg::KIND_READ;
            default:              o_cmd.kind = nsr_pkg::KIND_NOP;
        endcase
    end

endmodule

`default_nettype wire

### design/nsr_cmd_fifo.sv
// Short command queue between the decode side and the execute side.
`timescale 1ns / 1ps
`default_nettype none

module nsr_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nsr_pkg::t_cmd  i_cmd,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output nsr_pkg::t_cmd       o_cmd
);

    nsr_pkg::t_cmd                    r_mem [nsr_pkg::CMDQ_DEPTH];
    logic [nsr_pkg::CMDQ_PTR_W-1:0]   r_wr_ptr;
    logic [nsr_pkg::CMDQ_PTR_W-1:0]   r_rd_ptr;
    logic [nsr_pkg::CMDQ_CNT_W-1:0]   r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_full  = (r_count == nsr_pkg::CMDQ_CNT_W'(nsr_pkg::CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/nsr_back.sv
// Execute side: sentence state, byte store, checks and the result register.
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_sentence_receiver_unit_assert.svh"

module nsr_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [nsr_pkg::TARGET_W-1:0]  i_cfg_data,
    input  wire logic                          i_cmd_valid,
    input  wire nsr_pkg::t_cmd                 i_cmd,
    output logic                               o_pop,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output nsr_pkg::t_event                    o_event,
    output logic [7:0]                         o_read_byte,
    output logic [nsr_pkg::COUNT_W-1:0]        o_length
);

    typedef enum logic [2:0] {
        MODE_SEARCH = 3'b001,
        MODE_BUFFER = 3'b010,
        MODE_MATCH  = 3'b100
    } t_mode;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        priority if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h57)};
        end else begin
            return 5'd0;
        end
    endfunction

    logic [7:0]                        r_store [nsr_pkg::MAX_LEN];
    logic [7:0]                        r_rd_data;
    logic [7:0]                        r_prefix [nsr_pkg::PREFIX_LEN];
    logic [7:0]                        r_tail [3];
    logic [nsr_pkg::TARGET_W-1:0]      r_target;
    t_mode                             r_mode, n_mode;
    logic [nsr_pkg::COUNT_W-1:0]       r_count, n_count;
    logic [7:0]                        r_xor, n_xor;
    logic                              r_out_valid;
    nsr_pkg::t_event                   r_out_event;
    logic [nsr_pkg::COUNT_W-1:0]       r_out_len;
    logic                              r_out_rd_ok;

    logic                              w_exec;
    logic                              w_append;
    logic                              w_rd_en;
    logic                              w_rd_ok;
    nsr_pkg::t_event                   w_event;
    logic                              w_pfx_ok;
    logic                              w_csum_ok;
    logic                              w_complete;
    logic [4:0]                        w_hi;
    logic [4:0]                        w_lo;
    logic [7:0]                        w_sum;

    assign w_exec = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_exec;

    // Prefix compare over the first bytes actually stored; a shared zero ends it.
    always_comb begin : prefix_cmp
        logic       done;
        logic [7:0] s;
        logic [7:0] t;
        done     = 1'b0;
        w_pfx_ok = 1'b1;
        for (int i = 0; i < nsr_pkg::PREFIX_LEN; i++) begin
            s = r_prefix[i];
            t = r_target[8 * (nsr_pkg::PREFIX_LEN - 1 - i) +: 8];
            if (!done && (nsr_pkg::COUNT_W'(i) < r_count)) begin
                if (fold_case(s) != fold_case(t)) begin
                    w_pfx_ok = 1'b0;
                    done     = 1'b1;
                end else if (s == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
    end

    assign w_hi       = hex_digit(r_tail[1]);
    assign w_lo       = hex_digit(r_tail[0]);
    assign w_sum      = r_xor ^ r_tail[0] ^ r_tail[1] ^ r_tail[2];
    assign w_csum_ok  = w_hi[4] && w_lo[4] && (w_sum == {w_hi[3:0], w_lo[3:0]});
    assign w_complete = (r_count > nsr_pkg::COUNT_W'(3)) && (r_tail[2] == nsr_pkg::CHAR_STAR);

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_xor    = r_xor;
        w_append = 1'b0;
        w_rd_en  = 1'b0;
        w_rd_ok  = 1'b0;
        w_event  = nsr_pkg::EV_NONE;
        unique case (i_cmd.kind)
            nsr_pkg::KIND_BYTE: begin
                unique case (r_mode)
                    MODE_SEARCH: begin
                        if (i_cmd.is_dollar) begin
                            w_append = 1'b1;
                            n_count  = nsr_pkg::COUNT_W'(1);
                            n_xor    = 8'h00;
                            n_mode   = MODE_BUFFER;
                        end
                    end
                    MODE_BUFFER: begin
                        priority if (w_complete) begin
                            if (!w_pfx_ok) begin
                                w_event = nsr_pkg::EV_PREFIX;
                                n_mode  = MODE_SEARCH;
                                n_count = '0;
                                n_xor   = 8'h00;
                            end else if (!w_csum_ok) begin
                                w_event = nsr_pkg::EV_CSUM;
                                n_mode  = MODE_SEARCH;
                                n_count = '0;
                                n_xor   = 8'h00;
                            end else begin
                                w_event = nsr_pkg::EV_MATCH;
                                n_mode  = MODE_MATCH;
                            end
                        end else if (i_cmd.is_dollar
                                     || r_count >= nsr_pkg::COUNT_W'(nsr_pkg::MAX_LEN)) begin
                            w_event = nsr_pkg::EV_ABORT;
                            n_mode  = MODE_SEARCH;
                            n_count = '0;
                            n_xor   = 8'h00;
                        end else if (i_cmd.is_crlf) begin
                            w_event = nsr_pkg::EV_NONE;
                        end else begin
                            w_append = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_xor    = r_xor ^ i_cmd.data;
                        end
                    end
                    MODE_MATCH: ;
                    default: ;
                endcase
            end
            nsr_pkg::KIND_RELEASE: begin
                if (r_mode == MODE_MATCH) begin
                    n_mode  = MODE_SEARCH;
                    n_count = '0;
                    n_xor   = 8'h00;
                end
            end
            nsr_pkg::KIND_READ: begin
                w_event = nsr_pkg::EV_READ;
                w_rd_en = 1'b1;
                w_rd_ok = (nsr_pkg::COUNT_W'(i_cmd.idx) < r_count);
            end
            default: ;
        endcase
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_exec && w_append) begin
            r_store[r_count[nsr_pkg::ADDR_W-1:0]] <= i_cmd.data;
        end
        if (w_exec && w_rd_en) begin
            r_rd_data <= r_store[nsr_pkg::ADDR_W'(i_cmd.idx)];
        end
    end

    // Shadow copies of the head and the last three stored bytes for the checks.
    always_ff @(posedge i_clk) begin
        if (w_exec && w_append) begin
            if (r_count < nsr_pkg::COUNT_W'(nsr_pkg::PREFIX_LEN)) begin
                r_prefix[r_count[nsr_pkg::PFX_IDX_W-1:0]] <= i_cmd.data;
            end
            r_tail[2] <= r_tail[1];
            r_tail[1] <= r_tail[0];
            r_tail[0] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_mode      <= MODE_SEARCH;
            r_count     <= '0;
            r_xor       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end
            if (w_exec) begin
                r_mode      <= n_mode;
                r_count     <= n_count;
                r_xor       <= n_xor;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_event <= w_event;
            r_out_len   <= n_count;
            r_out_rd_ok <= w_rd_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event     = r_out_event;
    assign o_length    = r_out_len;
    assign o_read_byte = r_out_rd_ok ? r_rd_data : 8'h00;

    `NSR_ASSERT_ALWAYS(a_count_bound,
        r_count <= nsr_pkg::COUNT_W'(nsr_pkg::MAX_LEN),
        "stored count beyond store depth")
    `NSR_ASSERT_IMPLIES(a_search_empty,
        r_mode == MODE_SEARCH, r_count == '0 && r_xor == 8'h00,
        "search mode with stored bytes")
    `NSR_ASSERT_IMPLIES(a_buffer_nonempty,
        r_mode != MODE_SEARCH, r_count != '0,
        "sentence mode with empty store")
    `NSR_ASSERT_NEXT(a_release,
        w_exec && i_cmd.kind == nsr_pkg::KIND_RELEASE && r_mode == MODE_MATCH,
        r_mode == MODE_SEARCH && r_count == '0,
        "release did not clear held sentence")
    `NSR_ASSERT_IMPLIES(a_stall_no_exec,
        r_out_valid && !i_out_ready, !o_pop,
        "command executed into a stalled result")

endmodule

`default_nettype wire

### design/nmea_sentence_receiver_unit.sv
// Top level of the NMEA sentence receiver: decode, command queue and execute.
//
// Usage:
//   s_* carries one word per received item: s_tuser is the action (byte, release,
//   read), s_tdata holds the serial byte and the read position. m_* returns one
//   result word for every accepted input word, in order: m_tuser is the event code,
//   m_tdata holds the read byte and the number of stored sentence bytes.
//   The cfg channel writes the 48-bit wanted sentence prefix, first character in
//   the top byte, always ready; write only while the block is idle (not enforced).
// Timing:
//   An accepted word waits in the command queue and goes to the result register
//   once that is free. One word is taken and one result produced per cycle while
//   m_tready is high; execute updates the sentence state and byte store together.
// Stalls:
//   While m_tready is low the result register holds and up to four decoded
//   commands wait in the queue; s_tready drops once the queue is full.
// Reset:
//   Synchronous, active low: searching for '$', nothing stored, prefix cleared,
//   queue and result register empty. Store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_receiver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] byte_in, [14:8] read_index, [15] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] read_byte, [15:8] sentence_length
    output logic [2:0]       m_tuser,   // [2:0] event_res
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [47:0] i_cfg_data
);

    logic                             w_full;
    logic                             w_push;
    nsr_pkg::t_cmd                    w_front_cmd;
    logic                             w_q_valid;
    nsr_pkg::t_cmd                    w_q_cmd;
    logic                             w_pop;
    nsr_pkg::t_event                  w_event;
    logic [7:0]                       w_read_byte;
    logic [nsr_pkg::COUNT_W-1:0]      w_length;

    assign o_cfg_ready = 1'b1;

    nsr_front u_front (
        .i_tvalid     (s_tvalid),
        .o_tready     (s_tready),
        .i_action     (s_tuser),
        .i_byte       (s_tdata[7:0]),
        .i_idx        (s_tdata[14:8]),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    nsr_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    nsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_event     (w_event),
        .o_read_byte (w_read_byte),
        .o_length    (w_length)
    );

    assign m_tuser = w_event;
    assign m_tdata = {nsr_pkg::LEN_W'(w_length), w_read_byte};

endmodule

`default_nettype wire
